>>> rtl/core/lcs3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs3_pkg
// Shared constants, command codes and the cell-to-cell record of the
// three-string LCS engine.
// ----------------------------------------------------------------------------
package lcs3_pkg;

  localparam int MAX_LEN = 32;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int DRN_W   = $clog2(MAX_LEN + 2);
  localparam int SYM_W   = 8;
  localparam int VAL_W   = 6;

  typedef enum logic [1:0] {
    FUNC_LOAD_FIRST  = 2'd0,
    FUNC_LOAD_SECOND = 2'd1,
    FUNC_LOAD_THIRD  = 2'd2,
    FUNC_COMPUTE     = 2'd3
  } func_t;

  // One (i, j) pair travelling down the row of cells.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             first_row;
    logic [IDX_W-1:0] jidx;
    logic [SYM_W-1:0] a;
    logic [SYM_W-1:0] b;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] diag;
  } lcs3_pipe_t;

endpackage

>>> rtl/core/lcs3_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs3_cmd_if
// Command channel: load a symbol into one string, or start a computation.
// ----------------------------------------------------------------------------
interface lcs3_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] symbol;

  modport source (output valid, func, symbol, input ready);
  modport sink   (input valid, func, symbol, output ready);
endinterface

>>> rtl/core/lcs3_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs3_res_if
// Result channel: LCS length and the overflow flag.
// ----------------------------------------------------------------------------
interface lcs3_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] lcs_length;
  logic       overflow;

  modport source (output valid, lcs_length, overflow, input ready);
  modport sink   (input valid, lcs_length, overflow, output ready);
endinterface

>>> rtl/core/lcs3_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs3_cell
// One column k of the LCS table: holds the column for all j of the current
// plane and computes one table entry per cycle.
// ----------------------------------------------------------------------------
module lcs3_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lcs3_pkg::SYM_W-1:0] c,
  input  lcs3_pkg::lcs3_pipe_t      pin,
  output lcs3_pkg::lcs3_pipe_t      pout
);
  import lcs3_pkg::*;

  logic [VAL_W-1:0] col [MAX_LEN];
  logic [VAL_W-1:0] self_prev;
  logic [VAL_W-1:0] up_last;
  logic [VAL_W-1:0] old;
  logic [VAL_W-1:0] side;
  logic [VAL_W-1:0] best;
  logic [VAL_W-1:0] val;
  logic             jfirst;
  logic             match;

  always_comb begin
    old    = pin.first_row ? '0 : col[pin.jidx];
    jfirst = (pin.jidx == '0);
    side   = jfirst ? '0 : self_prev;
    match  = (pin.a == pin.b) && (pin.a == c);
    best   = old;
    if (pin.left > best) begin
      best = pin.left;
    end
    if (side > best) begin
      best = side;
    end
    val = match ? pin.diag + VAL_W'(1) : best;
  end

  always_ff @(posedge clk) begin
    if (pin.valid) begin
      col[pin.jidx] <= val;
      self_prev     <= val;
      up_last       <= old;
    end
  end

  // Only the valid bit is reset; the payload follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pout.valid <= 1'b0;
    end else begin
      pout.valid <= pin.valid;
    end
    pout.last      <= pin.last;
    pout.first_row <= pin.first_row;
    pout.jidx      <= pin.jidx;
    pout.a         <= pin.a;
    pout.b         <= pin.b;
    pout.left      <= val;
    pout.diag      <= jfirst ? '0 : up_last;
  end

endmodule

>>> rtl/core/lcs_three_strings_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_three_strings_length
// Length of the longest common subsequence of three strings, computed on a
// row of systolic cells.
// ----------------------------------------------------------------------------
// Symbols are loaded one per cycle with func 0, 1 or 2, appended to the first,
// second or third string; a symbol sent to a full string (MAX_LEN symbols) is
// dropped and sets the overflow flag. func 3 starts a computation and blocks
// the command channel until the result has been handed to the result
// register. When all three strings hold symbols the sequencer feeds one
// (i, j) pair per cycle, i over the first string and j over the second, into
// a row of MAX_LEN cells, one per position of the third string; after the
// last pair a drain counter covers the injection register, the row and the
// capture of the answer. When any string is empty the sequencer is skipped
// and the block goes straight to the drain. If the previous result has not
// yet been taken, the block waits further until its transfer.
// After the result transfer is queued, the strings and the flag are cleared.
// ----------------------------------------------------------------------------
module lcs_three_strings_length (
  input logic clk,
  input logic rst,
  lcs3_cmd_if.sink   cmd,
  lcs3_res_if.source res
);
  import lcs3_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;

  // String storage. The third string sits next to the cells, one symbol each.
  logic [SYM_W-1:0] first_str  [MAX_LEN];
  logic [SYM_W-1:0] second_str [MAX_LEN];
  logic [SYM_W-1:0] third_str  [MAX_LEN];
  logic [CNT_W-1:0] n1;
  logic [CNT_W-1:0] n2;
  logic [CNT_W-1:0] n3;
  logic             ovf;

  // Sequencer over the first and second strings.
  logic [IDX_W-1:0] i_idx;
  logic [IDX_W-1:0] j_idx;
  logic [DRN_W-1:0] drain_cnt;
  logic             i_end;
  logic             j_end;

  // pipe[k] is the input of cell k; pipe[k] for k >= 1 carries D[i][j][k].
  lcs3_pipe_t       pipe [MAX_LEN+1];
  lcs3_pipe_t       pipe_in;

  logic [VAL_W-1:0] out_len;
  logic             out_ovf;
  logic             out_valid;
  logic [VAL_W-1:0] result_len;
  logic             cmd_fire;
  logic             emit;

  assign cmd.ready      = (state == ST_LOAD);
  assign cmd_fire       = cmd.valid && cmd.ready;
  assign res.valid      = out_valid;
  assign res.lcs_length = out_len;
  assign res.overflow   = out_ovf;

  assign i_end = (CNT_W'(i_idx) + CNT_W'(1) == n1);
  assign j_end = (CNT_W'(j_idx) + CNT_W'(1) == n2);
  // The result is written once the last pair has left the row and the result register is free.
  assign emit  = (state == ST_DRAIN) && (drain_cnt == DRN_W'(MAX_LEN + 1)) &&
                 (!out_valid || res.ready);

  // Loading the strings.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      case (func_t'(cmd.func))
        FUNC_LOAD_FIRST: begin
          if (n1 < CNT_W'(MAX_LEN)) begin
            first_str[n1[IDX_W-1:0]] <= cmd.symbol;
          end
        end
        FUNC_LOAD_SECOND: begin
          if (n2 < CNT_W'(MAX_LEN)) begin
            second_str[n2[IDX_W-1:0]] <= cmd.symbol;
          end
        end
        FUNC_LOAD_THIRD: begin
          if (n3 < CNT_W'(MAX_LEN)) begin
            third_str[n3[IDX_W-1:0]] <= cmd.symbol;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control: counts, overflow flag, sequencer, result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      n1        <= '0;
      n2        <= '0;
      n3        <= '0;
      ovf       <= 1'b0;
      i_idx     <= '0;
      j_idx     <= '0;
      drain_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (cmd_fire) begin
            case (func_t'(cmd.func))
              FUNC_LOAD_FIRST: begin
                if (n1 < CNT_W'(MAX_LEN)) n1 <= n1 + CNT_W'(1);
                else                      ovf <= 1'b1;
              end
              FUNC_LOAD_SECOND: begin
                if (n2 < CNT_W'(MAX_LEN)) n2 <= n2 + CNT_W'(1);
                else                      ovf <= 1'b1;
              end
              FUNC_LOAD_THIRD: begin
                if (n3 < CNT_W'(MAX_LEN)) n3 <= n3 + CNT_W'(1);
                else                      ovf <= 1'b1;
              end
              FUNC_COMPUTE: begin
                i_idx     <= '0;
                j_idx     <= '0;
                drain_cnt <= '0;
                if (n1 == '0 || n2 == '0 || n3 == '0) state <= ST_DRAIN;
                else                                  state <= ST_RUN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (j_end) begin
            j_idx <= '0;
            if (i_end) begin
              state <= ST_DRAIN;
            end else begin
              i_idx <= i_idx + IDX_W'(1);
            end
          end else begin
            j_idx <= j_idx + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (drain_cnt != DRN_W'(MAX_LEN + 1)) begin
            drain_cnt <= drain_cnt + DRN_W'(1);
          end
          if (emit) begin
            out_valid <= 1'b1;
            n1        <= '0;
            n2        <= '0;
            n3        <= '0;
            ovf       <= 1'b0;
            state     <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_len <= result_len;
      out_ovf <= ovf;
    end
  end

  // Injection into the first cell, with zero boundaries on the k = 0 side.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_in.valid <= 1'b0;
    end else begin
      pipe_in.valid <= (state == ST_RUN);
    end
    pipe_in.last      <= i_end && j_end;
    pipe_in.first_row <= (i_idx == '0);
    pipe_in.jidx      <= j_idx;
    pipe_in.a         <= first_str[i_idx];
    pipe_in.b         <= second_str[j_idx];
    pipe_in.left      <= '0;
    pipe_in.diag      <= '0;
  end

  assign pipe[0] = pipe_in;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lcs3_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .c    (third_str[k]),
      .pin  (pipe[k]),
      .pout (pipe[k+1])
    );
  end

  // The answer is D[n1][n2][n3], seen when the last pair leaves cell n3 - 1.
  // It stays zero when a string is empty.
  always_ff @(posedge clk) begin
    if (cmd_fire && func_t'(cmd.func) == FUNC_COMPUTE) begin
      result_len <= '0;
    end else begin
      for (int k = 1; k <= MAX_LEN; k++) begin
        if (pipe[k].valid && pipe[k].last && n3 == CNT_W'(k)) begin
          result_len <= pipe[k].left;
        end
      end
    end
  end

endmodule

>>> bench/lcs_three_strings_length_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_three_strings_length_test
// Self-checking bench for the three-string LCS length engine.
// ----------------------------------------------------------------------------
// Loads strings through the command channel and starts computations. Each
// result is compared with a software model of the LCS recurrence that the
// bench keeps itself. Directed jobs from a short table run first, then full
// strings with overflow, then random jobs, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module lcs_three_strings_length_test;
  import lcs3_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [5:0] lcs_length;
    logic       overflow;
  } lcs_result_t;

  // One row of the directed table. A known length of -1 means the row is
  // checked against the model only.
  typedef struct {
    func_t      func;
    logic [7:0] symbol;
    int         known_length;
    int         known_overflow;
  } directed_row_t;

  logic clk;
  logic rst;

  lcs3_cmd_if cmd ();
  lcs3_res_if res ();

  lcs_three_strings_length DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res)
  );

  // The bench's own copy of the strings and the flag.
  logic [7:0]  strings_held [3][MAX_LEN];
  int          counts_held [3];
  logic        overflow_held;
  lcs_result_t lengths_due [$];

  int mismatches;
  int results_seen;
  int commands_sent;
  int computes_sent;
  int idle_count;

  directed_row_t directed_rows [$];

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = ~clk;
    end
  end

  // Three-dimensional recurrence with two rolling planes.
  function automatic logic [5:0] lcs_of_held();
    int plane [2][MAX_LEN + 1][MAX_LEN + 1];
    int prev;
    int cur;
    int best;
    prev = 0;
    cur = 1;
    for (int j = 0; j <= MAX_LEN; j++) begin
      for (int k = 0; k <= MAX_LEN; k++) begin
        plane[0][j][k] = 0;
        plane[1][j][k] = 0;
      end
    end
    for (int i = 1; i <= counts_held[0]; i++) begin
      for (int j = 0; j <= counts_held[1]; j++) plane[cur][j][0] = 0;
      for (int k = 0; k <= counts_held[2]; k++) plane[cur][0][k] = 0;
      for (int j = 1; j <= counts_held[1]; j++) begin
        for (int k = 1; k <= counts_held[2]; k++) begin
          if (strings_held[0][i-1] == strings_held[1][j-1] &&
              strings_held[0][i-1] == strings_held[2][k-1]) begin
            plane[cur][j][k] = plane[prev][j-1][k-1] + 1;
          end else begin
            best = plane[prev][j][k];
            if (plane[cur][j-1][k] > best) best = plane[cur][j-1][k];
            if (plane[cur][j][k-1] > best) best = plane[cur][j][k-1];
            plane[cur][j][k] = best;
          end
        end
      end
      prev = cur;
      cur = 1 - cur;
    end
    return plane[prev][counts_held[1]][counts_held[2]][5:0];
  endfunction

  // Applies one accepted command to the model; a compute queues a result.
  task automatic predict_command(input func_t f, input logic [7:0] sym,
                                 input int known_length, input int known_overflow);
    lcs_result_t r;
    int s;
    if (f == FUNC_COMPUTE) begin
      r.lcs_length = lcs_of_held();
      r.overflow = overflow_held;
      // Typed-in values must agree with the model too.
      if (known_length >= 0 && (r.lcs_length != known_length ||
                                r.overflow != known_overflow)) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("table row disagrees: typed %0d/%0d, model %0d/%0d",
                   known_length, known_overflow, r.lcs_length, r.overflow);
        end
      end
      lengths_due.push_back(r);
      counts_held = '{0, 0, 0};
      overflow_held = 1'b0;
    end else begin
      s = int'(f);
      if (counts_held[s] < MAX_LEN) begin
        strings_held[s][counts_held[s]] = sym;
        counts_held[s]++;
      end else begin
        overflow_held = 1'b1;
      end
    end
  endtask

  // Presents one command after a random gap and waits for its transfer.
  // Valid stays high after the transfer; the next call or the caller lowers it.
  task automatic send_command(input func_t f, input logic [7:0] sym,
                              input int known_length, input int known_overflow);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.func <= f;
    cmd.symbol <= sym;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predict_command(f, sym, known_length, known_overflow);
    commands_sent++;
    if (f == FUNC_COMPUTE) computes_sent++;
  endtask

  // Result side: a random stall per result, then compare the transfer with
  // the oldest expectation.
  initial begin
    lcs_result_t want;
    int gap;
    res.ready = 1'b0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!(res.valid && res.ready));
      results_seen++;
      if (lengths_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: length %0d", res.lcs_length);
      end else begin
        want = lengths_due.pop_front();
        if (want.lcs_length != res.lcs_length || want.overflow != res.overflow) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected length %0d overflow %0b, got %0d %0b",
                     results_seen, want.lcs_length, want.overflow,
                     res.lcs_length, res.overflow);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  initial begin
    idle_count = 0;
    forever begin
      @(posedge clk);
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", lengths_due.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Appends a string of given length drawn from a small or full alphabet.
  task automatic send_string(input func_t f, input int len, input int alphabet);
    for (int n = 0; n < len; n++) begin
      send_command(f, (alphabet == 256) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, alphabet - 1)), -1, -1);
    end
  endtask

  task automatic build_table();
    // Empty strings give zero.
    directed_rows.push_back('{FUNC_COMPUTE, 8'h00, 0, 0});
    // One common symbol, the top byte value.
    directed_rows.push_back('{FUNC_LOAD_FIRST, 8'hFF, -1, -1});
    directed_rows.push_back('{FUNC_LOAD_SECOND, 8'hFF, -1, -1});
    directed_rows.push_back('{FUNC_LOAD_THIRD, 8'hFF, -1, -1});
    directed_rows.push_back('{FUNC_COMPUTE, 8'hA5, 1, 0});
    // No common symbol.
    directed_rows.push_back('{FUNC_LOAD_FIRST, 8'h00, -1, -1});
    directed_rows.push_back('{FUNC_LOAD_SECOND, 8'h00, -1, -1});
    directed_rows.push_back('{FUNC_LOAD_THIRD, 8'h01, -1, -1});
    directed_rows.push_back('{FUNC_COMPUTE, 8'h00, 0, 0});
    // One string left empty.
    directed_rows.push_back('{FUNC_LOAD_FIRST, 8'h55, -1, -1});
    directed_rows.push_back('{FUNC_LOAD_SECOND, 8'h55, -1, -1});
    directed_rows.push_back('{FUNC_COMPUTE, 8'hFF, 0, 0});
    // Mixed short strings, model-checked.
    directed_rows.push_back('{FUNC_LOAD_FIRST, 8'h41, -1, -1});
    directed_rows.push_back('{FUNC_LOAD_FIRST, 8'h42, -1, -1});
    directed_rows.push_back('{FUNC_LOAD_SECOND, 8'h42, -1, -1});
    directed_rows.push_back('{FUNC_LOAD_SECOND, 8'h41, -1, -1});
    directed_rows.push_back('{FUNC_LOAD_THIRD, 8'h41, -1, -1});
    directed_rows.push_back('{FUNC_LOAD_THIRD, 8'h42, -1, -1});
    directed_rows.push_back('{FUNC_COMPUTE, 8'h00, -1, -1});
  endtask

  initial begin
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.func = FUNC_LOAD_FIRST;
    cmd.symbol = 8'h00;
    mismatches = 0;
    results_seen = 0;
    commands_sent = 0;
    computes_sent = 0;
    counts_held = '{0, 0, 0};
    overflow_held = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_table();
    foreach (directed_rows[n]) begin
      send_command(directed_rows[n].func, directed_rows[n].symbol,
                   directed_rows[n].known_length, directed_rows[n].known_overflow);
    end

    // Full strings of one repeated symbol, with one dropped symbol per string:
    // the longest length and the overflow flag together.
    for (int s = 0; s < 3; s++) begin
      for (int n = 0; n <= MAX_LEN; n++) begin
        send_command(func_t'(s), 8'h7E, -1, -1);
      end
    end
    send_command(FUNC_COMPUTE, 8'h00, MAX_LEN, 1);
    cmd.valid <= 1'b0;

    // Hold off until the pipeline has drained.
    while (lengths_due.size() != 0) @(posedge clk);

    // Random jobs: mostly short strings over small alphabets so matches are
    // common, now and then long strings, full strings or overflow.
    while (commands_sent < 1900) begin
      int pick;
      int alphabet;
      pick = $urandom_range(0, 19);
      alphabet = (pick < 6) ? 2 : (pick < 14) ? 4 : (pick < 18) ? 16 : 256;
      for (int s = 0; s < 3; s++) begin
        int len;
        if (pick == 19) len = $urandom_range(MAX_LEN - 2, MAX_LEN + 2);
        else if (pick == 18) len = $urandom_range(10, 20);
        else len = $urandom_range(0, 8);
        send_string(func_t'(s), len, alphabet);
      end
      send_command(FUNC_COMPUTE, 8'($urandom_range(0, 255)), -1, -1);
    end
    cmd.valid <= 1'b0;

    while (lengths_due.size() != 0) @(posedge clk);
    repeat (MAX_LEN + 10) @(posedge clk);

    $display("Sent %0d commands including %0d computations; checked %0d results.",
             commands_sent, computes_sent, results_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
